[design/two_dimensional_parity_corrector_assert.svh]
// ----------------------------------------------------------------------------
// two_dimensional_parity_corrector_assert.svh
// Assertion macros used by the parity corrector's checker.
// ----------------------------------------------------------------------------
`ifndef TWO_DIMENSIONAL_PARITY_CORRECTOR_ASSERT_SVH
`define TWO_DIMENSIONAL_PARITY_CORRECTOR_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TDPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define TDPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[design/tdpc_pkg.sv]
// ----------------------------------------------------------------------------
// tdpc_pkg
// Types and status codes of the two-dimensional parity corrector.
// ----------------------------------------------------------------------------
package tdpc_pkg;

   localparam int BYTE_W = 8;
   localparam int COL_W  = 3;
   localparam int ROW_W  = 6;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_CLEAN        = 2'd0;
   localparam status_type STATUS_CORRECTED    = 2'd1;
   localparam status_type STATUS_UNRESOLVABLE = 2'd2;
   localparam status_type STATUS_NO_ROWS      = 2'd3;

endpackage

[design/two_dimensional_parity_corrector.sv]
// ----------------------------------------------------------------------------
// two_dimensional_parity_corrector
// Receiver of a two-dimensional even-parity code: stores rows, checks row
// parity, builds column parity, corrects a single located bit and replays
// the stored rows with a status on every check item.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | beat carries
//   ---------+-----+--------------------+-----------------------------------------
//   req_     | in  | req_valid/ready    | is_check_row, data_byte, row_parity,
//            |     |                    | column_parity
//   rsp_     | out | rsp_valid/ready    | out_byte, status, error_row,
//            |     |                    | error_column, last
//
// Sequencing: data beats are taken back to back while the sequencer is idle.
//   A check beat starts a replay of one memory read (ST_READ) and then the
//   result beat (ST_SEND) per stored row, set by the single read port of
//   the row store; a check with no rows goes straight to its one beat.
// Reset: clears the run counters and the sequencer; the row store is not
//   cleared, since a replay only reads rows written in the same run.
// Stalls: a low rsp_ready holds the current result beat; req_ready stays
//   low from the accepted check beat until the last result beat is taken.
// ----------------------------------------------------------------------------
module two_dimensional_parity_corrector
   import tdpc_pkg::*;
#(
   parameter int MAX_ROWS = 64
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_is_check_row,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_row_parity,
   input  logic [BYTE_W-1:0] req_column_parity,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output status_type        rsp_status,
   output logic [ROW_W-1:0]  rsp_error_row,
   output logic [COL_W-1:0]  rsp_error_column,
   output logic              rsp_last
);

   localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W  = $clog2(MAX_ROWS + 1);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;   // take data and check beats
   localparam logic [1:0] ST_READ = 2'd1;   // read the next stored row
   localparam logic [1:0] ST_SEND = 2'd2;   // offer the result beat

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  rows_held_ff, rows_held_in;
   logic [BYTE_W-1:0] col_sum_ff, col_sum_in;
   logic              row_seen_ff, row_seen_in;
   logic [ADDR_W-1:0] mismatch_row_ff, mismatch_row_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] last_idx_ff, last_idx_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] err_row_ff, err_row_in;
   logic [COL_W-1:0]  err_col_ff, err_col_in;

   // row store: one write port for arriving rows, one registered read port
   logic [BYTE_W-1:0] row_store [MAX_ROWS];
   logic [BYTE_W-1:0] rd_data_ff;

   logic              req_fire;
   logic              row_write;
   logic [BYTE_W-1:0] col_diff;
   logic              col_seen;
   logic [COL_W-1:0]  col_calc;
   logic [BYTE_W-1:0] fix_mask;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   // rows past the limit are dropped without trace
   assign row_write = req_fire && !req_is_check_row && (rows_held_ff != CNT_W'(MAX_ROWS));

   // Column syndrome: the highest mismatching column is the lowest set bit.
   always_comb begin
      col_diff = col_sum_ff ^ req_column_parity;
      col_seen = |col_diff;
      col_calc = '0;
      for (int b = BYTE_W - 1; b >= 0; b--) begin
         if (col_diff[b]) begin
            col_calc = COL_W'(BYTE_W - 1 - b);
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      rows_held_in    = rows_held_ff;
      col_sum_in      = col_sum_ff;
      row_seen_in     = row_seen_ff;
      mismatch_row_in = mismatch_row_ff;
      idx_in          = idx_ff;
      last_idx_in     = last_idx_ff;
      status_in       = status_ff;
      err_row_in      = err_row_ff;
      err_col_in      = err_col_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (row_write) begin
               // accumulate column parity and remember the last bad row
               col_sum_in   = col_sum_ff ^ req_data_byte;
               rows_held_in = rows_held_ff + CNT_W'(1);
               if ((^req_data_byte) != req_row_parity) begin
                  row_seen_in     = 1'b1;
                  mismatch_row_in = rows_held_ff[ADDR_W-1:0];
               end
            end else if (req_fire && req_is_check_row) begin
               idx_in = '0;
               if (rows_held_ff == '0) begin
                  status_in   = STATUS_NO_ROWS;
                  err_row_in  = '0;
                  err_col_in  = '0;
                  last_idx_in = '0;
                  state_in    = ST_SEND;
               end else begin
                  err_row_in  = row_seen_ff ? mismatch_row_ff : '0;
                  err_col_in  = col_calc;
                  last_idx_in = ADDR_W'(rows_held_ff - CNT_W'(1));
                  if (row_seen_ff && col_seen) begin
                     status_in = STATUS_CORRECTED;
                  end else if (!row_seen_ff && !col_seen) begin
                     status_in = STATUS_CLEAN;
                  end else begin
                     status_in = STATUS_UNRESOLVABLE;
                  end
                  state_in = ST_READ;
               end
               // start a fresh run
               rows_held_in    = '0;
               col_sum_in      = '0;
               row_seen_in     = 1'b0;
               mismatch_row_in = '0;
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rows_held_ff    <= '0;
         col_sum_ff      <= '0;
         row_seen_ff     <= 1'b0;
         mismatch_row_ff <= '0;
         idx_ff          <= '0;
         last_idx_ff     <= '0;
         status_ff       <= STATUS_CLEAN;
         err_row_ff      <= '0;
         err_col_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         rows_held_ff    <= rows_held_in;
         col_sum_ff      <= col_sum_in;
         row_seen_ff     <= row_seen_in;
         mismatch_row_ff <= mismatch_row_in;
         idx_ff          <= idx_in;
         last_idx_ff     <= last_idx_in;
         status_ff       <= status_in;
         err_row_ff      <= err_row_in;
         err_col_ff      <= err_col_in;
      end
   end

   // Store arriving rows; read the replay row every cycle (stable in SEND,
   // since nothing is written until the replay ends).
   always_ff @(posedge clock) begin
      if (row_write) begin
         row_store[rows_held_ff[ADDR_W-1:0]] <= req_data_byte;
      end
      rd_data_ff <= row_store[idx_ff];
   end

   // Flip the located bit on the fly as its row goes out.
   assign fix_mask = ((status_ff == STATUS_CORRECTED) && (idx_ff == err_row_ff))
                     ? (BYTE_W'(8'h80) >> err_col_ff) : '0;

   assign rsp_valid        = (state_ff == ST_SEND);
   assign rsp_out_byte     = (status_ff == STATUS_NO_ROWS) ? '0 : (rd_data_ff ^ fix_mask);
   assign rsp_status       = status_ff;
   assign rsp_error_row    = ROW_W'(err_row_ff);
   assign rsp_error_column = err_col_ff;
   assign rsp_last         = (idx_ff == last_idx_ff);

endmodule

[design/tdpc_checker.sv]
// ----------------------------------------------------------------------------
// tdpc_checker
// Port-level checks of the two-dimensional parity corrector.
// ----------------------------------------------------------------------------
`include "two_dimensional_parity_corrector_assert.svh"

module tdpc_checker
   import tdpc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input status_type        rsp_status,
   input logic [ROW_W-1:0]  rsp_error_row,
   input logic [COL_W-1:0]  rsp_error_column,
   input logic              rsp_last
);

   logic            empty_beat;
   logic            empty_beat_ok;
   logic            clean_beat;
   logic            no_location;
   logic            rsp_stall;
   logic [BYTE_W:0] rsp_beat;

   assign no_location   = (rsp_error_row == '0) && (rsp_error_column == '0);
   assign empty_beat    = rsp_valid && (rsp_status == STATUS_NO_ROWS);
   assign empty_beat_ok = rsp_last && (rsp_out_byte == '0) && no_location;
   assign clean_beat    = rsp_valid && (rsp_status == STATUS_CLEAN);
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_beat      = {rsp_out_byte, rsp_last};

   // no input beat is taken while a replay is under way
   `TDPC_ASSERT(a_no_overlap, !(rsp_valid && req_ready), "input taken during replay")

   // an empty run gives one zero beat that closes the run
   `TDPC_ASSERT(a_empty_run, empty_beat |-> empty_beat_ok, "bad empty-run beat")

   // a clean run reports no error location
   `TDPC_ASSERT(a_clean_loc, clean_beat |-> no_location, "clean beat with error location")

   // a stalled result beat holds
   `TDPC_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_valid && $stable(rsp_beat)), "stalled beat changed")

   // nothing is offered straight after reset
   `TDPC_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result beat after reset")

endmodule

bind two_dimensional_parity_corrector tdpc_checker u_tdpc_checker (.*);

[tb/parity_replay_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parity_replay_checker
// Watches both channels of the parity corrector, keeps its own copy of the
// row store and run state, predicts the rows replayed for each check beat
// and compares them field by field with the result beats.
// ----------------------------------------------------------------------------
module parity_replay_checker
   import tdpc_pkg::*;
#(
   parameter int MAX_ROWS = 64
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_is_check_row,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_row_parity,
   input  logic [BYTE_W-1:0] req_column_parity,

   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BYTE_W-1:0] rsp_out_byte,
   input  status_type        rsp_status,
   input  logic [ROW_W-1:0]  rsp_error_row,
   input  logic [COL_W-1:0]  rsp_error_column,
   input  logic              rsp_last,

   output int                mismatch_count,
   output int                replay_backlog,
   output int                rows_compared
);

   typedef struct packed {
      logic [BYTE_W-1:0] row_byte;
      status_type        status;
      logic [ROW_W-1:0]  error_row;
      logic [COL_W-1:0]  error_column;
      logic              final_row;
   } replay_row_type;

   logic [BYTE_W-1:0] stored_rows [2**ROW_W];
   int                row_count;
   logic [BYTE_W-1:0] column_sum;
   logic              row_fault;
   logic [ROW_W-1:0]  fault_row;
   replay_row_type    expected_rows [$];
   int                mismatch_total = 0;
   int                compared_total = 0;

   assign mismatch_count = mismatch_total;
   assign rows_compared  = compared_total;

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_total++;
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic clear_run();
      row_count  = 0;
      column_sum = '0;
      row_fault  = 1'b0;
      fault_row  = '0;
   endtask

   task automatic store_row(input logic [BYTE_W-1:0] data, input logic parity);
      // drop rows once the store is full
      if (row_count < MAX_ROWS) begin
         stored_rows[row_count[ROW_W-1:0]] = data;
         if ((^data) != parity) begin
            row_fault = 1'b1;
            fault_row = row_count[ROW_W-1:0];
         end
         column_sum ^= data;
         row_count++;
      end
   endtask

   task automatic predict_replay(input logic [BYTE_W-1:0] column_in);
      logic [BYTE_W-1:0] column_diff;
      logic [COL_W-1:0]  column_hit;
      status_type        run_status;
      replay_row_type    beat;
      column_diff = column_sum ^ column_in;
      column_hit  = '0;
      if (row_count == 0) begin
         beat.row_byte     = '0;
         beat.status       = STATUS_NO_ROWS;
         beat.error_row    = '0;
         beat.error_column = '0;
         beat.final_row    = 1'b1;
         expected_rows.push_back(beat);
      end else begin
         // last mismatching column = lowest set bit of the difference
         for (int b = BYTE_W - 1; b >= 0; b--) begin
            if (column_diff[b]) column_hit = COL_W'(BYTE_W - 1 - b);
         end
         if (row_fault && column_diff != '0) begin
            stored_rows[fault_row] ^= 8'h80 >> column_hit;
            run_status = STATUS_CORRECTED;
         end else if (!row_fault && column_diff == '0) begin
            run_status = STATUS_CLEAN;
         end else begin
            run_status = STATUS_UNRESOLVABLE;
         end
         for (int i = 0; i < row_count; i++) begin
            beat.row_byte     = stored_rows[i];
            beat.status       = run_status;
            beat.error_row    = fault_row;
            beat.error_column = column_hit;
            beat.final_row    = (i == row_count - 1);
            expected_rows.push_back(beat);
         end
      end
      clear_run();
   endtask

   task automatic compare_replayed_row();
      replay_row_type want;
      if (expected_rows.size() == 0) begin
         report_mismatch("result beat with no row expected", rsp_out_byte, 0);
      end else begin
         want = expected_rows.pop_front();
         compared_total++;
         if (rsp_out_byte !== want.row_byte)
            report_mismatch("out_byte", rsp_out_byte, want.row_byte);
         if (rsp_status !== want.status)
            report_mismatch("status", rsp_status, want.status);
         if (rsp_error_row !== want.error_row)
            report_mismatch("error_row", rsp_error_row, want.error_row);
         if (rsp_error_column !== want.error_column)
            report_mismatch("error_column", rsp_error_column, want.error_column);
         if (rsp_last !== want.final_row)
            report_mismatch("last", rsp_last, want.final_row);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_run();
         expected_rows.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_replayed_row();
         if (req_valid && req_ready) begin
            if (req_is_check_row) predict_replay(req_column_parity);
            else store_row(req_data_byte, req_row_parity);
         end
      end
      replay_backlog <= expected_rows.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives runs of data beats closed by a check beat into the two-dimensional
// parity corrector: clean runs, single flipped bits, row-only and
// column-only faults, noisy runs and runs past the row limit, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench
   import tdpc_pkg::*;
();

   localparam int ROW_LIMIT     = 64;
   localparam int RANDOM_ITEMS  = 500;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;

   // Result-side stall patterns
   typedef enum int {READY_STEADY, READY_COIN, READY_SPARSE} ready_mode_type;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic              req_is_check_row  = 1'b0;
   logic [BYTE_W-1:0] req_data_byte     = '0;
   logic              req_row_parity    = 1'b0;
   logic [BYTE_W-1:0] req_column_parity = '0;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   status_type        rsp_status;
   logic [ROW_W-1:0]  rsp_error_row;
   logic [COL_W-1:0]  rsp_error_column;
   logic              rsp_last;

   logic              draining          = 1'b0;
   int                mismatch_count;
   int                replay_backlog;
   int                rows_compared;
   int                cycle_count       = 0;
   int                items_sent        = 0;
   int                checks_sent       = 0;
   int                rows_dropped      = 0;
   int                burst_left        = 0;
   ready_mode_type    ready_mode        = READY_STEADY;
   int                ready_left        = 0;
   logic [BYTE_W-1:0] block_rows [$];

   two_dimensional_parity_corrector #(
      .MAX_ROWS(ROW_LIMIT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_is_check_row (req_is_check_row),
      .req_data_byte    (req_data_byte),
      .req_row_parity   (req_row_parity),
      .req_column_parity(req_column_parity),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_status       (rsp_status),
      .rsp_error_row    (rsp_error_row),
      .rsp_error_column (rsp_error_column),
      .rsp_last         (rsp_last)
   );

   parity_replay_checker #(
      .MAX_ROWS(ROW_LIMIT)
   ) u_replay_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_is_check_row (req_is_check_row),
      .req_data_byte    (req_data_byte),
      .req_row_parity   (req_row_parity),
      .req_column_parity(req_column_parity),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_status       (rsp_status),
      .rsp_error_row    (rsp_error_row),
      .rsp_error_column (rsp_error_column),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .replay_backlog   (replay_backlog),
      .rows_compared    (rows_compared)
   );

   always #5 clock = ~clock;

   // Hard stop: a hung handshake or a lost result beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d result beats still owed",
                  CYCLE_LIMIT, replay_backlog);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result-side back-pressure: switch between always ready, a coin toss per
   // cycle and long stalls broken by single ready cycles. Hold ready high
   // once the stimulus has finished so the tail drains.
   always @(posedge clock) begin
      if (draining) begin
         rsp_ready <= 1'b1;
      end else begin
         if (ready_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 2));
            ready_left <= $urandom_range(8, 40);
         end else begin
            ready_left <= ready_left - 1;
         end
         case (ready_mode)
            READY_STEADY: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            default:      rsp_ready <= (ready_left % 6 == 0);
         endcase
      end
   end

   // Present one request beat and hold it until accepted. Bursts of random
   // length are separated by random gaps; some bursts start with no gap at
   // all, giving long back-to-back stretches. Return at the accepting edge,
   // so the caller may put the next beat on the bus in the same step.
   task automatic send_beat(input logic check, input logic [BYTE_W-1:0] data,
                            input logic parity, input logic [BYTE_W-1:0] column);
      int idle_gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (idle_gap != 0) begin
            req_valid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_is_check_row  <= check;
      req_data_byte     <= data;
      req_row_parity    <= parity;
      req_column_parity <= column;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (check) checks_sent++;
   endtask

   // Send the rows held in block_rows followed by the check beat. Row and
   // column parities are taken from the rows as sent, then the given flips
   // are applied: a flip on row r together with column c looks exactly like
   // a single corrupted bit. Rows past the limit are dropped by the block,
   // so leave them out of the column sum and give them random parity.
   task automatic send_run(input logic [63:0] parity_flips, input logic [BYTE_W-1:0] column_flips);
      logic [BYTE_W-1:0] column_sum;
      logic              parity_bit;
      column_sum = '0;
      foreach (block_rows[i]) begin
         if (i < ROW_LIMIT) begin
            column_sum ^= block_rows[i];
            parity_bit = (^block_rows[i]) ^ parity_flips[i];
         end else begin
            parity_bit = 1'($urandom_range(0, 1));
            rows_dropped++;
         end
         send_beat(1'b0, block_rows[i], parity_bit, 8'($urandom));
      end
      send_beat(1'b1, 8'($urandom), 1'($urandom), column_sum ^ column_flips);
   endtask

   // One random run: mostly short, now and then empty or near the store's
   // size or past it. Most runs are well formed (clean or one flipped bit);
   // the rest carry a row-only fault, a column-only fault or plain noise.
   task automatic random_run();
      int                roll;
      int                length;
      int                held;
      int                bad_row;
      logic [COL_W-1:0]  bad_col;
      logic [63:0]       parity_flips;
      logic [BYTE_W-1:0] column_flips;
      roll = $urandom_range(0, 99);
      if (roll < 8) length = 0;
      else if (roll < 16) length = $urandom_range(ROW_LIMIT - 4, ROW_LIMIT + 6);
      else length = $urandom_range(1, 8);
      block_rows.delete();
      repeat (length) block_rows.push_back(8'($urandom));
      held         = (length < ROW_LIMIT) ? length : ROW_LIMIT;
      parity_flips = '0;
      column_flips = '0;
      roll         = $urandom_range(0, 99);
      if (held != 0) begin
         bad_row = $urandom_range(0, held - 1);
         bad_col = 3'($urandom_range(0, 7));
         if (roll < 35) begin
            // clean run: leave everything consistent
         end else if (roll < 70) begin
            block_rows[bad_row] ^= 8'h80 >> bad_col;
            parity_flips[bad_row] = 1'b1;
            column_flips = 8'h80 >> bad_col;
         end else if (roll < 80) begin
            parity_flips[bad_row] = 1'b1;
         end else if (roll < 90) begin
            column_flips = 8'h80 >> bad_col;
         end else begin
            parity_flips = {$urandom, $urandom};
            column_flips = 8'($urandom);
         end
      end else begin
         column_flips = 8'($urandom);
      end
      send_run(parity_flips, column_flips);
   endtask

   initial begin
      int stop_at;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      // Check with nothing stored, column parity all ones.
      block_rows.delete();
      send_run(64'h0, 8'hFF);
      // Clean run on the byte extremes.
      block_rows = '{8'h00, 8'hFF};
      send_run(64'h0, 8'h00);
      // Single bit flipped in the last column of the last row.
      block_rows = '{8'hFF, 8'h00, 8'h5B};
      send_run(64'h4, 8'h01);
      // One-row run with the first column flipped.
      block_rows = '{8'h81};
      send_run(64'h1, 8'h80);
      // Row fault with no column fault: left uncorrected.
      block_rows = '{8'h12, 8'h34};
      send_run(64'h2, 8'h00);
      // Column fault with no row fault: left uncorrected.
      block_rows = '{8'h80, 8'h40, 8'h20};
      send_run(64'h0, 8'h10);
      // Two bad rows and two bad columns: fix the last of each.
      block_rows = '{8'hC3, 8'h3C, 8'hE7};
      send_run(64'h5, 8'h60);

      // Random part.
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) random_run();

      // Drop valid, let the tail drain, then settle for stray beats.
      req_valid <= 1'b0;
      draining  <= 1'b1;
      repeat (2) @(posedge clock);
      while (replay_backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d request beats in %0d runs, %0d rows beyond the store limit",
               items_sent, checks_sent, rows_dropped);
      $display("checked %0d replayed rows, %0d mismatches", rows_compared, mismatch_count);
      if (mismatch_count == 0 && replay_backlog == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
